>>> src/gmj_pkg.sv
// ----------------------------------------------------------------------------
// gmj_pkg
// Types and constants shared by the grid metric jacobian core.
// ----------------------------------------------------------------------------
package gmj_pkg;

  localparam int DW      = 32;              // field width
  localparam int FRAC    = 16;              // fraction bits
  localparam int PROD_W  = 2 * DW;          // product of two fields
  localparam int COF_W   = 2 * DW + 1;      // signed cofactor
  localparam int CMAG_W  = 2 * DW;          // cofactor magnitude
  localparam int DET_W   = 3 * DW + 1;      // signed determinant
  localparam int DMAG_W  = 3 * DW;          // determinant magnitude
  localparam int NUM_IN  = 9;
  localparam int NUM_COF = 9;
  localparam int LANES   = 10;              // nine metric terms and inv_det
  localparam int STEPS   = DW;              // quotient bits, one per stage
  // inv_det numerator 2^(4F) starts the division as 2^(4F-DW)
  localparam logic [CMAG_W-1:0] INV_START = CMAG_W'(1) << (4 * FRAC - DW);
  localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NEG_MAG = {1'b1, {(DW-1){1'b0}}};

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEG  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // cofactor k = v[A]*v[B] - v[C]*v[D]
  localparam int COF_A [NUM_COF] = '{4, 6, 3, 7, 0, 6, 1, 3, 0};
  localparam int COF_B [NUM_COF] = '{8, 5, 7, 2, 8, 1, 5, 2, 4};
  localparam int COF_C [NUM_COF] = '{7, 3, 6, 1, 6, 0, 4, 0, 3};
  localparam int COF_D [NUM_COF] = '{5, 8, 4, 8, 2, 7, 2, 5, 1};

  typedef struct packed {
    logic signed [DW-1:0] x_by_xi;
    logic signed [DW-1:0] y_by_xi;
    logic signed [DW-1:0] z_by_xi;
    logic signed [DW-1:0] x_by_eta;
    logic signed [DW-1:0] y_by_eta;
    logic signed [DW-1:0] z_by_eta;
    logic signed [DW-1:0] x_by_zeta;
    logic signed [DW-1:0] y_by_zeta;
    logic signed [DW-1:0] z_by_zeta;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] xi_over_x;
    logic signed [DW-1:0] xi_over_y;
    logic signed [DW-1:0] xi_over_z;
    logic signed [DW-1:0] eta_over_x;
    logic signed [DW-1:0] eta_over_y;
    logic signed [DW-1:0] eta_over_z;
    logic signed [DW-1:0] zeta_over_x;
    logic signed [DW-1:0] zeta_over_y;
    logic signed [DW-1:0] zeta_over_z;
    logic signed [DW-1:0] inv_det;
    logic [1:0]           status;
  } out_t;

  typedef struct packed {
    logic                         valid;
    logic [DET_W-1:0]             det;
    logic [NUM_COF-1:0][COF_W-1:0] cof;
  } front_t;

  typedef struct packed {
    logic [DMAG_W-1:0] rem;
    logic [DW-1:0]     q;
    logic              neg;
    logic              big;
  } lane_t;

  typedef struct packed {
    logic                   valid;
    logic [DMAG_W-1:0]      dmag;
    logic                   dneg;
    logic                   dzero;
    logic [LANES-1:0][$bits(lane_t)-1:0] lane;
  } div_t;

endpackage

>>> src/gmj_front.sv
// ----------------------------------------------------------------------------
// gmj_front
// Products, cofactors and the exact determinant over five register stages.
// ----------------------------------------------------------------------------
module gmj_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gmj_pkg::in_t  args,
  output gmj_pkg::front_t front
);
  import gmj_pkg::*;

  logic                     v1_valid, p2_valid, c3_valid, d4_valid;
  logic signed [DW-1:0]     v1 [NUM_IN];
  logic signed [PROD_W-1:0] pa2 [NUM_COF];
  logic signed [PROD_W-1:0] pb2 [NUM_COF];
  logic signed [DW-1:0]     v2 [3];
  logic signed [COF_W-1:0]  cof3 [NUM_COF];
  logic signed [DW-1:0]     v3 [3];
  logic signed [COF_W-1:0]  cof4 [NUM_COF];
  logic signed [COF_W-1:0]  lo4 [3];
  logic signed [COF_W-1:0]  hi4 [3];
  logic signed [DET_W-1:0]  det_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_valid    <= 1'b0;
      p2_valid    <= 1'b0;
      c3_valid    <= 1'b0;
      d4_valid    <= 1'b0;
      front.valid <= 1'b0;
    end else begin
      v1_valid    <= start;
      p2_valid    <= v1_valid;
      c3_valid    <= p2_valid;
      d4_valid    <= c3_valid;
      front.valid <= d4_valid;
    end
    v1[0] <= args.x_by_xi;   v1[1] <= args.y_by_xi;   v1[2] <= args.z_by_xi;
    v1[3] <= args.x_by_eta;  v1[4] <= args.y_by_eta;  v1[5] <= args.z_by_eta;
    v1[6] <= args.x_by_zeta; v1[7] <= args.y_by_zeta; v1[8] <= args.z_by_zeta;
    for (int k = 0; k < NUM_COF; k++) begin
      pa2[k]  <= v1[COF_A[k]] * v1[COF_B[k]];
      pb2[k]  <= v1[COF_C[k]] * v1[COF_D[k]];
      cof3[k] <= COF_W'(pa2[k]) - COF_W'(pb2[k]);
      cof4[k] <= cof3[k];
    end
    for (int j = 0; j < 3; j++) begin
      v2[j] <= v1[3*j];
      v3[j] <= v2[j];
      // split the cofactor so each multiply stays near 32 bits
      lo4[j] <= COF_W'(v3[j]) * COF_W'($signed({1'b0, cof3[3*j][DW-1:0]}));
      hi4[j] <= COF_W'(v3[j]) * COF_W'($signed(cof3[3*j][COF_W-1:DW]));
    end
    front.det <= det_next;
    for (int k = 0; k < NUM_COF; k++) front.cof[k] <= cof4[k];
  end

  always_comb begin
    det_next = '0;
    for (int j = 0; j < 3; j++)
      det_next = det_next + (DET_W'(hi4[j]) <<< DW) + DET_W'(lo4[j]);
  end

endmodule

>>> src/gmj_div_step.sv
// ----------------------------------------------------------------------------
// gmj_div_step
// One restoring division step for all lanes, one quotient bit, registered.
// ----------------------------------------------------------------------------
module gmj_div_step (
  input  logic          clk,
  input  logic          rst,
  input  gmj_pkg::div_t pin,
  output gmj_pkg::div_t pout
);
  import gmj_pkg::*;

  lane_t            li [LANES];
  lane_t            lo [LANES];
  logic [DMAG_W:0]  rem2 [LANES];
  logic             ge [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      li[i]   = lane_t'(pin.lane[i]);
      rem2[i] = {li[i].rem, 1'b0};
      ge[i]   = rem2[i] >= {1'b0, pin.dmag};
      lo[i]   = li[i];
      lo[i].rem = ge[i] ? DMAG_W'(rem2[i] - {1'b0, pin.dmag}) : DMAG_W'(rem2[i]);
      lo[i].q   = {li[i].q[DW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout.valid <= 1'b0;
    end else begin
      pout.valid <= pin.valid;
    end
    pout.dmag  <= pin.dmag;
    pout.dneg  <= pin.dneg;
    pout.dzero <= pin.dzero;
    for (int i = 0; i < LANES; i++) pout.lane[i] <= lo[i];
  end

endmodule

>>> src/grid_metric_jacobian_core.sv
// ----------------------------------------------------------------------------
// grid_metric_jacobian_core
// Inverse metric terms and cell jacobian of one curvilinear grid point.
// ----------------------------------------------------------------------------
// usage:
//   drive args with the nine Q16.16 coordinate derivatives and pulse start;
//   a transfer happens at each edge with start high and busy low. busy is
//   always low, so one point can be taken every cycle.
//   done is high for one cycle with the result; the receiver must take it
//   then, since the pipeline cannot be held.
// pipeline: a point passes 5 stages of products, cofactors and determinant,
//   1 setup stage, 32 division stages with one quotient bit each and
//   1 output stage, which registers done with the result.
// throughput: one point per cycle; ten divider lanes run side by side.
// status: ok, negative jacobian (values still given), or zero determinant
//   (all values zero). quotients saturate to the Q16.16 range.
// reset: clears the valid bits; points in flight are dropped.
// ----------------------------------------------------------------------------
module grid_metric_jacobian_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gmj_pkg::in_t  args,
  output logic          busy,
  output logic          done,
  output gmj_pkg::out_t result
);
  import gmj_pkg::*;

  front_t            front;
  div_t              chain [STEPS+1];
  div_t              init_next;
  logic [DET_W-1:0]  det_abs;
  logic [COF_W-1:0]  cof_abs;
  lane_t             ln;
  lane_t             fin [LANES];
  logic [DW-1:0]     val [LANES];
  logic              qneg;

  assign busy = 1'b0;

  gmj_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .args  (args),
    .front (front)
  );

  // setup: magnitudes, signs and overflow check per lane
  always_comb begin
    init_next       = '0;
    init_next.valid = front.valid;
    init_next.dneg  = front.det[DET_W-1];
    det_abs         = front.det[DET_W-1] ? DET_W'(-front.det) : front.det;
    init_next.dmag  = det_abs[DMAG_W-1:0];
    init_next.dzero = front.det == '0;
    for (int i = 0; i < LANES; i++) begin
      ln = '0;
      if (i < NUM_COF) begin
        cof_abs = front.cof[i][COF_W-1] ? COF_W'(-front.cof[i]) : front.cof[i];
        ln.neg  = front.cof[i][COF_W-1];
        ln.rem  = DMAG_W'(cof_abs[CMAG_W-1:0]);
      end else begin
        cof_abs = '0;
        ln.rem  = DMAG_W'(INV_START);
      end
      // quotient would reach 2^DW: saturates either way
      ln.big = ln.rem >= init_next.dmag;
      init_next.lane[i] = ln;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= init_next.valid;
    end
    chain[0].dmag  <= init_next.dmag;
    chain[0].dneg  <= init_next.dneg;
    chain[0].dzero <= init_next.dzero;
    chain[0].lane  <= init_next.lane;
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    gmj_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .pin  (chain[s]),
      .pout (chain[s+1])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      fin[i] = lane_t'(chain[STEPS].lane[i]);
      qneg   = (fin[i].neg != chain[STEPS].dneg) && (fin[i].big || fin[i].q != '0);
      if (chain[STEPS].dzero) begin
        val[i] = '0;
      end else if (qneg) begin
        val[i] = (fin[i].big || fin[i].q > NEG_MAG) ? NEG_MAG : DW'(-fin[i].q);
      end else begin
        val[i] = (fin[i].big || fin[i].q > POS_MAX) ? POS_MAX : fin[i].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[STEPS].valid;
    end
    result.xi_over_x   <= val[0];
    result.xi_over_y   <= val[1];
    result.xi_over_z   <= val[2];
    result.eta_over_x  <= val[3];
    result.eta_over_y  <= val[4];
    result.eta_over_z  <= val[5];
    result.zeta_over_x <= val[6];
    result.zeta_over_y <= val[7];
    result.zeta_over_z <= val[8];
    result.inv_det     <= val[9];
    if (chain[STEPS].dzero) begin
      result.status <= ST_ZERO;
    end else if (chain[STEPS].dneg) begin
      result.status <= ST_NEG;
    end else begin
      result.status <= ST_OK;
    end
  end

endmodule
